>>> sv/pic_pkg.sv
package pic_pkg;

   localparam int NUM_SOURCES_DEFAULT = 96;
   localparam int NUM_CTX             = 2;
   localparam int CTX_W               = 1;
   localparam int OWNER_W             = 2;

   localparam logic [22:0] PEND_BASE  = 23'h001000;
   localparam logic [22:0] ENAB_BASE  = 23'h002000;
   localparam logic [22:0] CTX_BASE   = 23'h200000;
   localparam logic [22:0] REGION_END = 23'h600000;
   localparam logic [11:0] REG_THRESHOLD = 12'h000;
   localparam logic [11:0] REG_CLAIM     = 12'h004;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_RAISE = 2'd2;
   localparam logic [1:0] ACT_LOWER = 2'd3;

   typedef logic [2:0] op_type;
   localparam op_type OP_NONE     = 3'd0;
   localparam op_type OP_PRIO_RD  = 3'd1;
   localparam op_type OP_PRIO_WR  = 3'd2;
   localparam op_type OP_PEND_RD  = 3'd3;
   localparam op_type OP_CLAIM    = 3'd4;
   localparam op_type OP_COMPLETE = 3'd5;
   localparam op_type OP_LINE     = 3'd6;

endpackage

>>> sv/platform_interrupt_controller_unit.sv
// Platform interrupt controller with priority, pending, enable, threshold and
// claim/complete registers for every source and context. Every item (bus read,
// bus write, line raise or line lower) runs one pass over the per-source memory,
// one source per cycle. Its result is registered in the finishing state after the
// pass, and the next item is accepted only after that, back in the idle state.
// The single read port of the source record memory, one record a cycle, sets the
// length of the pass. A result that the receiver has not yet taken holds the end
// of the next item's pass until it is taken. After reset the block first clears
// the source memory and accepts no item during that time. One result comes back
// per item.
module platform_interrupt_controller_unit #(
   parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // action, offset, access_size, write_data, line_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // read_data, status, eip_mask, wake_mask
);

   localparam int NC     = pic_pkg::NUM_CTX;
   localparam int CW     = pic_pkg::CTX_W;
   localparam int OW     = pic_pkg::OWNER_W;
   localparam int LOGN   = $clog2(NUM_SOURCES);
   localparam int IW     = (LOGN < 6) ? 6 : LOGN;
   localparam int NWORDS = (NUM_SOURCES + 31) / 32;
   localparam int RW     = 32 + OW + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;

   logic [1:0]  in_action;
   logic [22:0] in_offset;
   logic [3:0]  in_size;
   logic [31:0] in_wdata;
   logic [6:0]  in_sid;
   assign in_action = req_tdata[1:0];
   assign in_offset = req_tdata[24:2];
   assign in_size   = req_tdata[28:25];
   assign in_wdata  = req_tdata[60:29];
   assign in_sid    = req_tdata[67:61];

   logic [2:0]              state_ff, state_in;
   logic [IW:0]             cnt_ff, cnt_in;
   logic                    pv_ff, pv_in;
   logic [IW-1:0]           ps_ff, ps_in;
   pic_pkg::op_type         op_ff, op_in;
   logic [IW-1:0]           tgt_ff, tgt_in;
   logic [9:0]              widx_ff, widx_in;
   logic [CW-1:0]           ctx_ff, ctx_in;
   logic [31:0]             wdata_ff, wdata_in;
   logic                    lval_ff, lval_in;
   logic                    fault_ff, fault_in;
   logic [31:0]             rdata_ff, rdata_in;
   logic [IW-1:0]           best_ff, best_in;
   logic [31:0]             bprio_ff, bprio_in;
   logic [1:0]              dcnt_ff [NC], dcnt_in [NC];
   logic [IW-1:0]           dfirst_ff [NC], dfirst_in [NC];
   logic [NC-1:0]           pend_ff, pend_in;
   logic [NWORDS*32-1:0]    enab_ff [NC], enab_in [NC];
   logic [31:0]             thr_ff [NC], thr_in [NC];
   logic                    rsp_v_ff, rsp_v_in;
   logic [39:0]             rsp_d_ff, rsp_d_in;

   logic [RW-1:0]           mem [NUM_SOURCES];
   logic [RW-1:0]           mem_rd_ff;
   logic                    mem_we;
   logic [IW-1:0]           mem_wa, mem_ra;
   logic [RW-1:0]           mem_wd;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   always_comb begin
      logic [22:0]   bo;
      logic [13:0]   ec;
      logic [4:0]    ew;
      logic [9:0]    cc;
      logic [11:0]   rr;
      logic [31:0]   rprio, nprio;
      logic [OW-1:0] rown, nown;
      logic          rline, nline, pbit, hit, dl;
      logic [NC-1:0] eip;
      bo = '0; ec = '0; ew = '0; cc = '0; rr = '0;
      rprio = mem_rd_ff[RW-1 -: 32];
      rown  = mem_rd_ff[OW:1];
      rline = mem_rd_ff[0];
      nprio = rprio; nown = rown; nline = rline; pbit = 1'b0; hit = 1'b0; dl = 1'b0;
      eip = '0;
      state_in = state_ff; cnt_in = cnt_ff; pv_in = 1'b0; ps_in = ps_ff;
      op_in = op_ff; tgt_in = tgt_ff; widx_in = widx_ff; ctx_in = ctx_ff;
      wdata_in = wdata_ff; lval_in = lval_ff; fault_in = fault_ff; rdata_in = rdata_ff;
      best_in = best_ff; bprio_in = bprio_ff; pend_in = pend_ff;
      rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      for (int c = 0; c < NC; c++) begin
         dcnt_in[c] = dcnt_ff[c]; dfirst_in[c] = dfirst_ff[c];
         enab_in[c] = enab_ff[c]; thr_in[c] = thr_ff[c];
      end
      mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = cnt_ff[IW-1:0];
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[IW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(NUM_SOURCES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in = pic_pkg::OP_NONE; fault_in = 1'b0; rdata_in = '0;
               wdata_in = in_wdata; lval_in = (in_action == pic_pkg::ACT_RAISE);
               cnt_in = '0; best_in = '0; bprio_in = '0;
               for (int c = 0; c < NC; c++) dcnt_in[c] = '0;
               if (in_action == pic_pkg::ACT_READ || in_action == pic_pkg::ACT_WRITE) begin
                  if (in_size != 4'd4 || in_offset[1:0] != 2'b00 ||
                      in_offset >= pic_pkg::REGION_END) begin
                     fault_in = 1'b1;
                  end else if (in_offset < pic_pkg::PEND_BASE) begin
                     if (32'(in_offset[11:2]) < NUM_SOURCES) begin
                        tgt_in = IW'(in_offset[11:2]);
                        if (in_action == pic_pkg::ACT_READ) op_in = pic_pkg::OP_PRIO_RD;
                        else if (in_offset[11:2] != 10'd0) op_in = pic_pkg::OP_PRIO_WR;
                     end
                  end else if (in_offset < pic_pkg::ENAB_BASE) begin
                     if (in_action == pic_pkg::ACT_READ && 32'(in_offset[11:2]) < NWORDS) begin
                        op_in = pic_pkg::OP_PEND_RD;
                        widx_in = in_offset[11:2];
                     end
                  end else if (in_offset < pic_pkg::CTX_BASE) begin
                     bo = in_offset - pic_pkg::ENAB_BASE;
                     ec = bo[20:7];
                     ew = bo[6:2];
                     if (32'(ec) < NC && 32'(ew) < NWORDS) begin
                        if (in_action == pic_pkg::ACT_READ)
                           rdata_in = enab_ff[ec[CW-1:0]][32*ew +: 32];
                        else
                           enab_in[ec[CW-1:0]][32*ew +: 32] = in_wdata;
                     end
                  end else begin
                     bo = in_offset - pic_pkg::CTX_BASE;
                     cc = bo[21:12];
                     rr = bo[11:0];
                     if (32'(cc) < NC) begin
                        ctx_in = cc[CW-1:0];
                        if (rr == pic_pkg::REG_THRESHOLD) begin
                           if (in_action == pic_pkg::ACT_READ) rdata_in = thr_ff[cc[CW-1:0]];
                           else thr_in[cc[CW-1:0]] = in_wdata;
                        end else if (rr == pic_pkg::REG_CLAIM) begin
                           if (in_action == pic_pkg::ACT_READ) begin
                              op_in = pic_pkg::OP_CLAIM;
                           end else if (in_wdata != 32'd0 && in_wdata < NUM_SOURCES) begin
                              op_in = pic_pkg::OP_COMPLETE;
                              tgt_in = IW'(in_wdata);
                           end
                        end
                     end
                  end
               end else if (in_sid != 7'd0 && 32'(in_sid) < NUM_SOURCES) begin
                  op_in = pic_pkg::OP_LINE;
                  tgt_in = IW'(in_sid);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff < (IW+1)'(NUM_SOURCES)) begin
               pv_in = 1'b1;
               ps_in = cnt_ff[IW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
            if (pv_ff) begin
               hit = (ps_ff == tgt_ff);
               if (hit && op_ff == pic_pkg::OP_LINE) nline = lval_ff;
               if (hit && op_ff == pic_pkg::OP_COMPLETE && rown == OW'(ctx_ff) + 1'b1)
                  nown = '0;
               if (hit && op_ff == pic_pkg::OP_PRIO_WR) nprio = wdata_ff;
               if (hit && (op_ff == pic_pkg::OP_LINE || op_ff == pic_pkg::OP_COMPLETE ||
                           op_ff == pic_pkg::OP_PRIO_WR)) begin
                  mem_we = 1'b1;
                  mem_wa = ps_ff;
                  mem_wd = {nprio, nown, nline};
               end
               if (hit && op_ff == pic_pkg::OP_PRIO_RD) rdata_in = rprio;
               pbit = nline && nown == '0 && ps_ff != '0;
               if (op_ff == pic_pkg::OP_PEND_RD && (16'(ps_ff) >> 5) == 16'(widx_ff))
                  rdata_in[ps_ff[4:0]] = pbit;
               for (int c = 0; c < NC; c++) begin
                  dl = pbit && enab_ff[c][ps_ff] && nprio > thr_ff[c];
                  if (dl) begin
                     if (dcnt_ff[c] == 2'd0) dfirst_in[c] = ps_ff;
                     if (dcnt_ff[c] != 2'd2) dcnt_in[c] = dcnt_ff[c] + 1'b1;
                     if (op_ff == pic_pkg::OP_CLAIM && c == int'(ctx_ff) && nprio > bprio_ff)
                     begin
                        best_in = ps_ff;
                        bprio_in = nprio;
                     end
                  end
               end
               if (ps_ff == IW'(NUM_SOURCES - 1)) state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_v_ff || rsp_tready) begin
               for (int c = 0; c < NC; c++)
                  eip[c] = dcnt_ff[c] == 2'd2 || (dcnt_ff[c] == 2'd1 &&
                           !(op_ff == pic_pkg::OP_CLAIM && best_ff != '0 &&
                             dfirst_ff[c] == best_ff));
               if (op_ff == pic_pkg::OP_CLAIM && best_ff != '0) begin
                  mem_we = 1'b1;
                  mem_wa = best_ff;
                  mem_wd = {bprio_ff, OW'(ctx_ff) + 1'b1, 1'b1};
               end
               rsp_v_in = 1'b1;
               rsp_d_in = {3'b000, eip & ~pend_ff, eip, fault_ff,
                           (op_ff == pic_pkg::OP_CLAIM) ? 32'(best_ff) : rdata_ff};
               pend_in = eip;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         pv_ff    <= 1'b0;
         rsp_v_ff <= 1'b0;
         pend_ff  <= '0;
         for (int c = 0; c < NC; c++) begin
            enab_ff[c] <= '0;
            thr_ff[c]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
         rsp_v_ff <= rsp_v_in;
         pend_ff  <= pend_in;
         for (int c = 0; c < NC; c++) begin
            enab_ff[c] <= enab_in[c];
            thr_ff[c]  <= thr_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      ps_ff    <= ps_in;
      op_ff    <= op_in;
      tgt_ff   <= tgt_in;
      widx_ff  <= widx_in;
      ctx_ff   <= ctx_in;
      wdata_ff <= wdata_in;
      lval_ff  <= lval_in;
      fault_ff <= fault_in;
      rdata_ff <= rdata_in;
      best_ff  <= best_in;
      bprio_ff <= bprio_in;
      rsp_d_ff <= rsp_d_in;
      for (int c = 0; c < NC; c++) begin
         dcnt_ff[c]   <= dcnt_in[c];
         dfirst_ff[c] <= dfirst_in[c];
      end
   end

`ifndef SYNTH
   a_wake_in_eip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[36:35] & ~rsp_tdata[34:33]) == 2'b00)
      else $error("wake bit without pending bit");
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("faulting item returned read data");
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_SCAN)
      else $error("accepted item did not start a scan");
   a_fin_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && (!rsp_v_ff || rsp_tready) |=> rsp_tvalid)
      else $error("finished scan produced no result");
`endif

endmodule

>>> bench/pic_checker.sv
`timescale 1ns / 100ps

module pic_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          fail_count,
   output int          outstanding,
   output int          result_count
);

   localparam int NSRC = 96;
   localparam int NWORD = 3;

   typedef struct packed {
      logic [1:0]  wake_mask;
      logic [1:0]  eip_mask;
      logic        status;
      logic [31:0] read_data;
   } pic_result_type;

   logic        line_up [NSRC];
   logic [1:0]  owner [NSRC];
   logic [31:0] prio [NSRC];
   logic [31:0] thresh [pic_pkg::NUM_CTX];
   logic [31:0] enab [pic_pkg::NUM_CTX][NWORD];
   logic [1:0]  pend_q;
   pic_result_type awaited_results[$];
   int          mismatch_count;

   function automatic bit can_deliver(int c, int s);
      return enab[c][s / 32][s % 32] && line_up[s] && owner[s] == 2'd0
         && prio[s] > thresh[c];
   endfunction

   function automatic int pick_winner(int c);
      int best;
      logic [31:0] best_p;
      best = 0;
      best_p = 0;
      for (int s = 1; s < NSRC; s++)
         if (can_deliver(c, s) && prio[s] > best_p) begin
            best_p = prio[s];
            best = s;
         end
      return best;
   endfunction

   function automatic logic [31:0] read_reg(logic [22:0] off);
      int s, w, c, r;
      logic [31:0] v;
      if (off < pic_pkg::PEND_BASE) begin
         s = off / 4;
         return s < NSRC ? prio[s] : 32'd0;
      end
      if (off < pic_pkg::ENAB_BASE) begin
         w = (off - pic_pkg::PEND_BASE) / 4;
         if (w >= NWORD) return 32'd0;
         v = 0;
         for (int i = 0; i < 32; i++) begin
            s = w * 32 + i;
            if (s != 0 && s < NSRC && line_up[s] && owner[s] == 2'd0) v[i] = 1'b1;
         end
         return v;
      end
      if (off < pic_pkg::CTX_BASE) begin
         c = (off - pic_pkg::ENAB_BASE) / 'h80;
         w = ((off - pic_pkg::ENAB_BASE) % 'h80) / 4;
         return (c < pic_pkg::NUM_CTX && w < NWORD) ? enab[c][w] : 32'd0;
      end
      c = (off - pic_pkg::CTX_BASE) / 'h1000;
      r = (off - pic_pkg::CTX_BASE) % 'h1000;
      if (c >= pic_pkg::NUM_CTX) return 32'd0;
      if (r == pic_pkg::REG_THRESHOLD) return thresh[c];
      if (r == pic_pkg::REG_CLAIM) begin
         s = pick_winner(c);
         if (s != 0) owner[s] = 2'(c + 1);
         return 32'(s);
      end
      return 32'd0;
   endfunction

   function automatic void write_reg(logic [22:0] off, logic [31:0] v);
      int s, w, c, r;
      if (off < pic_pkg::PEND_BASE) begin
         s = off / 4;
         if (s != 0 && s < NSRC) prio[s] = v;
         return;
      end
      if (off < pic_pkg::ENAB_BASE) return;
      if (off < pic_pkg::CTX_BASE) begin
         c = (off - pic_pkg::ENAB_BASE) / 'h80;
         w = ((off - pic_pkg::ENAB_BASE) % 'h80) / 4;
         if (c < pic_pkg::NUM_CTX && w < NWORD) enab[c][w] = v;
         return;
      end
      c = (off - pic_pkg::CTX_BASE) / 'h1000;
      r = (off - pic_pkg::CTX_BASE) % 'h1000;
      if (c >= pic_pkg::NUM_CTX) return;
      if (r == pic_pkg::REG_THRESHOLD) thresh[c] = v;
      else if (r == pic_pkg::REG_CLAIM && v > 0 && v < NSRC && owner[v] == 2'(c + 1))
         owner[v] = 2'd0;
   endfunction

   function automatic pic_result_type apply_item(logic [71:0] d);
      pic_result_type res;
      logic [1:0]  action;
      logic [22:0] off;
      logic [3:0]  size;
      logic [31:0] wdata;
      logic [6:0]  sid;
      logic        now;
      action = d[1:0];
      off = d[24:2];
      size = d[28:25];
      wdata = d[60:29];
      sid = d[67:61];
      res = '0;
      if (action == pic_pkg::ACT_READ || action == pic_pkg::ACT_WRITE) begin
         if (size != 4'd4 || off[1:0] != 2'b00 || off >= pic_pkg::REGION_END)
            res.status = 1'b1;
         else if (action == pic_pkg::ACT_READ) res.read_data = read_reg(off);
         else write_reg(off, wdata);
      end else if (sid != 0 && sid < NSRC) begin
         line_up[sid] = (action == pic_pkg::ACT_RAISE);
      end
      for (int c = 0; c < pic_pkg::NUM_CTX; c++) begin
         now = 1'b0;
         for (int s = 1; s < NSRC; s++) if (can_deliver(c, s)) now = 1'b1;
         res.eip_mask[c] = now;
         res.wake_mask[c] = now && !pend_q[c];
         pend_q[c] = now;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      pic_result_type seen, want;
      if (reset) begin
         for (int s = 0; s < NSRC; s++) begin
            line_up[s] = 0;
            owner[s] = 0;
            prio[s] = 0;
         end
         for (int c = 0; c < pic_pkg::NUM_CTX; c++) begin
            thresh[c] = 0;
            for (int w = 0; w < NWORD; w++) enab[c][w] = 0;
         end
         pend_q = 0;
         awaited_results.delete();
         mismatch_count = 0;
         result_count = 0;
      end else begin
         if (req_tvalid && req_tready) awaited_results.push_back(apply_item(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[36:0];
            result_count = result_count + 1;
            if (awaited_results.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) $display("unexpected result %h", seen);
            end else begin
               want = awaited_results.pop_front();
               if (seen.read_data != want.read_data || seen.status != want.status
                     || seen.eip_mask != want.eip_mask
                     || seen.wake_mask != want.wake_mask) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("mismatch: rdata %h/%h status %b/%b eip %b/%b wake %b/%b",
                        want.read_data, seen.read_data, want.status, seen.status,
                        want.eip_mask, seen.eip_mask, want.wake_mask, seen.wake_mask);
               end
            end
         end
      end
      outstanding = awaited_results.size();
      fail_count = mismatch_count;
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // action, offset, access_size, write_data, line_source
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // read_data, status, eip_mask, wake_mask
   int          fail_count;
   int          outstanding;
   int          result_count;
   int          item_count = 0;
   bit          calm = 1'b0;
   bit          hold_off = 1'b0;

   platform_interrupt_controller_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   pic_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .outstanding(outstanding), .result_count(result_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, one long hold-off
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 17);
   end

   task automatic send_item(logic [1:0] action, logic [22:0] off, logic [3:0] size,
                            logic [31:0] wdata, logic [6:0] sid);
      while (!calm && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {4'd0, sid, wdata, size, off, action};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      item_count++;
   endtask

   task automatic idle_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic bus_rd(logic [22:0] off);
      send_item(pic_pkg::ACT_READ, off, 4'd4, $urandom, 7'($urandom));
   endtask

   task automatic bus_wr(logic [22:0] off, logic [31:0] v);
      send_item(pic_pkg::ACT_WRITE, off, 4'd4, v, 7'($urandom));
   endtask

   function automatic logic [22:0] pick_offset();
      int k;
      k = $urandom_range(9);
      case (k)
         0, 1: return 23'(4 * $urandom_range(100));
         2: return pic_pkg::PEND_BASE + 23'(4 * $urandom_range(3));
         3, 4: return pic_pkg::ENAB_BASE
                      + 23'('h80 * $urandom_range(2) + 4 * $urandom_range(3));
         5, 6, 7: return pic_pkg::CTX_BASE + 23'('h1000 * $urandom_range(2))
                         + pic_pkg::REG_CLAIM;
         8: return pic_pkg::CTX_BASE
                   + 23'('h1000 * $urandom_range(2) + 4 * $urandom_range(3));
         default: return 23'($urandom);
      endcase
   endfunction

   task automatic random_item();
      int k;
      logic [22:0] off;
      logic [3:0] size;
      k = $urandom_range(99);
      off = pick_offset();
      size = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd4;
      if ($urandom_range(19) == 0) off = 23'($urandom);
      if (k < 25) send_item(pic_pkg::ACT_RAISE, 23'($urandom), 4'($urandom), $urandom,
                            $urandom_range(9) == 0 ? 7'($urandom) : 7'($urandom_range(1, 95)));
      else if (k < 35) send_item(pic_pkg::ACT_LOWER, 23'($urandom), 4'($urandom), $urandom,
                            7'($urandom_range(127)));
      else if (k < 65) send_item(pic_pkg::ACT_READ, off, size, $urandom, 7'($urandom));
      else begin
         if (off >= pic_pkg::CTX_BASE && off[11:0] == pic_pkg::REG_CLAIM && $urandom_range(1))
            send_item(pic_pkg::ACT_WRITE, off, size, 32'($urandom_range(97)), 7'($urandom));
         else if (off >= pic_pkg::CTX_BASE && off[11:0] == pic_pkg::REG_THRESHOLD)
            send_item(pic_pkg::ACT_WRITE, off, size, 32'($urandom_range(4)), 7'($urandom));
         else if (off < pic_pkg::PEND_BASE)
            send_item(pic_pkg::ACT_WRITE, off, size,
                      $urandom_range(15) == 0 ? $urandom : 32'($urandom_range(6)),
                      7'($urandom));
         else send_item(pic_pkg::ACT_WRITE, off, size, $urandom, 7'($urandom));
      end
   endtask

   initial begin
      #400000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      calm = 1'b1;
      // directed
      bus_wr(23'd4, 32'hFFFF_FFFF);
      bus_wr(23'd4 * 95, 32'd3);
      bus_wr(23'd0, 32'd7);
      bus_wr(pic_pkg::ENAB_BASE, 32'hFFFF_FFFF);
      bus_wr(pic_pkg::ENAB_BASE + 23'h80 + 23'd8, 32'h8000_0000);
      send_item(pic_pkg::ACT_RAISE, 23'd0, 4'd0, 32'd0, 7'd1);
      send_item(pic_pkg::ACT_RAISE, 23'h7FFFFF, 4'hF, 32'hFFFF_FFFF, 7'd95);
      send_item(pic_pkg::ACT_RAISE, 23'd0, 4'd0, 32'd0, 7'd0);
      send_item(pic_pkg::ACT_RAISE, 23'd0, 4'd0, 32'd0, 7'd127);
      bus_rd(pic_pkg::PEND_BASE);
      bus_rd(pic_pkg::PEND_BASE + 23'd8);
      bus_rd(pic_pkg::CTX_BASE + pic_pkg::REG_CLAIM);
      bus_rd(pic_pkg::CTX_BASE + 23'h1000 + pic_pkg::REG_CLAIM);
      bus_wr(pic_pkg::CTX_BASE + pic_pkg::REG_CLAIM, 32'd95);
      bus_wr(pic_pkg::CTX_BASE + pic_pkg::REG_CLAIM, 32'd1);
      bus_wr(pic_pkg::CTX_BASE + 23'h1000, 32'hFFFF_FFFF);
      bus_wr(pic_pkg::PEND_BASE, 32'hFFFF_FFFF);
      bus_rd(pic_pkg::CTX_BASE + 23'h1000);
      send_item(pic_pkg::ACT_READ, 23'd6, 4'd4, 32'd0, 7'd0);
      send_item(pic_pkg::ACT_WRITE, 23'd8, 4'd8, 32'd1, 7'd0);
      send_item(pic_pkg::ACT_READ, pic_pkg::REGION_END, 4'd4, 32'd0, 7'd0);
      send_item(pic_pkg::ACT_READ, 23'h7FFFFC, 4'd1, 32'd0, 7'd0);
      bus_rd(pic_pkg::CTX_BASE + 23'h2000 + pic_pkg::REG_CLAIM);
      bus_rd(pic_pkg::CTX_BASE + 23'h8);
      send_item(pic_pkg::ACT_LOWER, 23'd0, 4'd0, 32'd0, 7'd1);
      calm = 1'b0;
      // random, with a calm stretch, a long receiver hold-off and a full drain
      for (int i = 0; i < 850; i++) begin
         calm = (i >= 200 && i < 300);
         if (i == 400) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (2000) @(negedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         if (i == 600) idle_until_drained();
         random_item();
      end
      calm = 1'b1;
      idle_until_drained();
      repeat (300) @(negedge clock);
      $display("covered %0d items, %0d results: register reads and writes, claims,",
               item_count, result_count);
      $display("completes, line events, faults and reserved offsets");
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
